/* rtl/qawc_pkg.sv */
// qawc_pkg: shared widths, constants, job and status structs and state encodings
// for the quad area-weighted centroid block. No dependencies.
package qawc_pkg;

   // vertex coordinates
   localparam int COORD_WIDTH = 32;
   localparam int CRD_W       = 32;
   localparam int NVTX_CRD    = 12;

   // datapath widths
   localparam int EDGE_W = CRD_W + 1;
   localparam int SUM_W  = CRD_W + 2;
   localparam int OPA_W  = SUM_W + 1;
   localparam int OPB_W  = 33;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int NRM_W  = 64;
   localparam int SQ_W   = 128;
   localparam int ROOT_W = 64;
   localparam int REM_W  = ROOT_W + 2;
   localparam int AREA_W = 63;
   localparam int MOM_W  = 128;
   localparam int DVS_W  = AREA_W + 2;
   localparam int CEN_W  = 32;

   // iteration counters
   localparam int SQ_CNT_W  = $clog2(ROOT_W);
   localparam int DIV_CNT_W = $clog2(MOM_W);

   // job queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [AREA_W-1:0] AREA_MAX    = '1;
   localparam logic [CEN_W-1:0]  CEN_POS_MAX = {1'b0, {(CEN_W-1){1'b1}}};
   localparam logic [CEN_W-1:0]  CEN_NEG_MAX = {1'b1, {(CEN_W-1){1'b0}}};

   // one quad (or a bare end of slice) handed from front to back
   typedef struct packed {
      logic                             quad;
      logic                             eos;
      logic [NVTX_CRD-1:0][CRD_W-1:0]   crd;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_EDGE,
      BS_CROSS,
      BS_SQRT,
      BS_MOMENT,
      BS_DSETUP,
      BS_DIV,
      BS_EMIT
   } bstate_type;

   // multiplier schedule of one triangle
   typedef enum logic [4:0] {
      MS_CX0, MS_CX1, MS_CY0, MS_CY1, MS_CZ0, MS_CZ1,
      MS_SQ0H, MS_SQ0M, MS_SQ0L,
      MS_SQ1H, MS_SQ1M, MS_SQ1L,
      MS_SQ2H, MS_SQ2M, MS_SQ2L,
      MS_MXL, MS_MXH, MS_MYL, MS_MYH, MS_MZL, MS_MZH,
      MS_DONE
   } mstep_type;

   // take the low COORD_WIDTH bits and sign-extend
   function automatic logic [CRD_W-1:0] sext_coord(input logic [CRD_W-1:0] c);
      logic signed [CRD_W-1:0] t;
      t = $signed(c << (CRD_W - COORD_WIDTH));
      return t >>> (CRD_W - COORD_WIDTH);
   endfunction

endpackage

/* rtl/qawc_fifo.sv */
// qawc_fifo: short job queue between the vertex front end and the triangle back end.
// Depends on qawc_pkg.
module qawc_fifo import qawc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head_job,
   output qstat_type qstat
);

   job_type               mem_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;

   // status and head
   assign qstat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign head_job    = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("job queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != QCNT_W'(QDEPTH)))
      else $error("push into full job queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("pop from empty job queue");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == QCNT_W'($past(cnt_ff) + 1'b1)))
      else $error("job queue count did not follow push");

endmodule

/* rtl/qawc_front.sv */
// qawc_front: takes vertex beats, gathers four into a quad and queues it as a job;
// an early end of slice is queued as a bare job. Depends on qawc_pkg.
module qawc_front import qawc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CRD_W-1:0] req_coord_x,
   input  logic [CRD_W-1:0] req_coord_y,
   input  logic [CRD_W-1:0] req_coord_z,
   input  logic             req_end_of_slice,
   input  qstat_type        qstat,
   output logic             push,
   output job_type          push_job
);

   logic [8:0][CRD_W-1:0] held_ff, held_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [2:0][CRD_W-1:0] p;
   logic                  accept;
   logic                  full_quad;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign full_quad = (cnt_ff == 2'd3);

   assign p[0] = sext_coord(req_coord_x);
   assign p[1] = sext_coord(req_coord_y);
   assign p[2] = sext_coord(req_coord_z);

   // job build: a completed quad, or a bare end of slice
   always_comb begin
      push          = accept && (full_quad || req_end_of_slice);
      push_job.quad = full_quad;
      push_job.eos  = req_end_of_slice;
      for (int i = 0; i < 9; i++) begin
         push_job.crd[i] = held_ff[i];
      end
      for (int k = 0; k < 3; k++) begin
         push_job.crd[9+k] = p[k];
      end
   end

   // vertex holding and count
   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         for (int v = 0; v < 3; v++) begin
            if (cnt_ff == 2'(v)) begin
               for (int k = 0; k < 3; k++) begin
                  held_in[v*3+k] = p[k];
               end
            end
         end
         cnt_in = (full_quad || req_end_of_slice) ? 2'd0 : cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

/* rtl/qawc_isqrt.sv */
// qawc_isqrt: iterative integer square root, one result bit per cycle, rounded down.
// Depends on qawc_pkg.
module qawc_isqrt import qawc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   logic [SQ_W-1:0]     val_ff, val_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [REM_W+1:0]    rem_t, trial, rem_sub;
   logic                ge;

   assign root = root_ff;
   assign done = done_ff;

   // one digit step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_t   = {rem_ff, val_ff[SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = (rem_t >= trial);
      rem_sub = rem_t - trial;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[SQ_W-3:0], 2'b00};
         rem_in  = ge ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

endmodule

/* rtl/qawc_div.sv */
// qawc_div: iterative restoring divider, one quotient bit per cycle.
// Depends on qawc_pkg.
module qawc_div import qawc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MOM_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [MOM_W-1:0] quotient,
   output logic             done
);

   logic [MOM_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     r_ff, r_in;
   logic [DVS_W-1:0]     d_ff, d_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       r_t, r_sub;
   logic                 ge;

   // quotient bits shift into the dividend register as it empties
   assign quotient = dvd_ff;
   assign done     = done_ff;

   always_comb begin
      r_t     = {r_ff, dvd_ff[MOM_W-1]};
      ge      = (r_t >= {1'b0, d_ff});
      r_sub   = r_t - {1'b0, d_ff};
      dvd_in  = dvd_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[MOM_W-2:0], ge};
         r_in   = ge ? r_sub[DVS_W-1:0] : r_t[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(MOM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* rtl/qawc_back.sv */
// qawc_back: per-quad triangle area and moment accumulation, slice centroid and
// result register. Depends on qawc_pkg, qawc_isqrt and qawc_div.
module qawc_back import qawc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  job_type           head_job,
   input  qstat_type         qstat,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CEN_W-1:0]  rsp_centroid_x,
   output logic [CEN_W-1:0]  rsp_centroid_y,
   output logic [CEN_W-1:0]  rsp_centroid_z,
   output logic [AREA_W-1:0] rsp_slice_area,
   output logic              rsp_area_zero
);

   bstate_type                state_ff, state_in;
   job_type                   job_ff, job_in;
   logic                      tri_ff, tri_in;
   logic signed [EDGE_W-1:0]  e_ff [3], e_in [3];
   logic signed [EDGE_W-1:0]  f_ff [3], f_in [3];
   logic signed [SUM_W-1:0]   s_ff [3], s_in [3];
   mstep_type                 iss_ff, iss_in;
   mstep_type                 ptag_ff, ptag_in;
   logic                      pvld_ff, pvld_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  cacc_ff, cacc_in;
   logic [NRM_W-1:0]          n_ff [3], n_in [3];
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [AREA_W-1:0]         area_ff, area_in;
   logic [AREA_W-1:0]         asum_ff, asum_in;
   logic [MOM_W-1:0]          mom_ff [3], mom_in [3];
   logic [1:0]                axis_ff, axis_in;
   logic                      neg_ff, neg_in;
   logic [CEN_W-1:0]          cen_ff [3], cen_in [3];
   logic                      zero_ff, zero_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CEN_W-1:0]          rsp_cx_ff, rsp_cy_ff, rsp_cz_ff;
   logic [AREA_W-1:0]         rsp_area_ff;
   logic                      rsp_zero_ff;

   logic [CRD_W-1:0]          va [3], vb [3], vc [3];
   logic signed [OPA_W-1:0]   opa;
   logic signed [OPB_W-1:0]   opb;
   logic signed [PROD_W-1:0]  diff, dmag;
   logic [ROOT_W-1:0]         root;
   logic                      sqrt_start, sqrt_done;
   logic [AREA_W-1:0]         area_v;
   logic [AREA_W:0]           asum_add;
   logic [MOM_W-1:0]          mom_sel, dvd;
   logic [DVS_W-1:0]          dvs;
   logic                      div_start, div_done;
   logic [MOM_W-1:0]          quot;
   logic [CEN_W-1:0]          cen_v;
   logic                      rsp_load;

   // iterative units
   qawc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   qawc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quot),
      .done     (div_done)
   );

   // triangle corners: (p1,p2,p3) then (p1,p3,p4)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         va[k] = job_ff.crd[k];
         vb[k] = tri_ff ? job_ff.crd[6+k] : job_ff.crd[3+k];
         vc[k] = tri_ff ? job_ff.crd[9+k] : job_ff.crd[6+k];
      end
   end

   // shared multiplier operand select
   always_comb begin
      opa = '0;
      opb = '0;
      case (iss_ff)
         MS_CX0: begin opa = OPA_W'(e_ff[1]); opb = OPB_W'(f_ff[2]); end
         MS_CX1: begin opa = OPA_W'(e_ff[2]); opb = OPB_W'(f_ff[1]); end
         MS_CY0: begin opa = OPA_W'(e_ff[2]); opb = OPB_W'(f_ff[0]); end
         MS_CY1: begin opa = OPA_W'(e_ff[0]); opb = OPB_W'(f_ff[2]); end
         MS_CZ0: begin opa = OPA_W'(e_ff[0]); opb = OPB_W'(f_ff[1]); end
         MS_CZ1: begin opa = OPA_W'(e_ff[1]); opb = OPB_W'(f_ff[0]); end
         MS_SQ0H: begin opa = {3'b000, n_ff[0][63:32]}; opb = {1'b0, n_ff[0][63:32]}; end
         MS_SQ0M: begin opa = {3'b000, n_ff[0][63:32]}; opb = {1'b0, n_ff[0][31:0]}; end
         MS_SQ0L: begin opa = {3'b000, n_ff[0][31:0]};  opb = {1'b0, n_ff[0][31:0]}; end
         MS_SQ1H: begin opa = {3'b000, n_ff[1][63:32]}; opb = {1'b0, n_ff[1][63:32]}; end
         MS_SQ1M: begin opa = {3'b000, n_ff[1][63:32]}; opb = {1'b0, n_ff[1][31:0]}; end
         MS_SQ1L: begin opa = {3'b000, n_ff[1][31:0]};  opb = {1'b0, n_ff[1][31:0]}; end
         MS_SQ2H: begin opa = {3'b000, n_ff[2][63:32]}; opb = {1'b0, n_ff[2][63:32]}; end
         MS_SQ2M: begin opa = {3'b000, n_ff[2][63:32]}; opb = {1'b0, n_ff[2][31:0]}; end
         MS_SQ2L: begin opa = {3'b000, n_ff[2][31:0]};  opb = {1'b0, n_ff[2][31:0]}; end
         MS_MXL: begin opa = OPA_W'(s_ff[0]); opb = {1'b0, area_ff[31:0]}; end
         MS_MXH: begin opa = OPA_W'(s_ff[0]); opb = {2'b00, area_ff[62:32]}; end
         MS_MYL: begin opa = OPA_W'(s_ff[1]); opb = {1'b0, area_ff[31:0]}; end
         MS_MYH: begin opa = OPA_W'(s_ff[1]); opb = {2'b00, area_ff[62:32]}; end
         MS_MZL: begin opa = OPA_W'(s_ff[2]); opb = {1'b0, area_ff[31:0]}; end
         MS_MZH: begin opa = OPA_W'(s_ff[2]); opb = {2'b00, area_ff[62:32]}; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   // cross component magnitude, divided by four and truncated to 64 bits unsigned (Q64.0)
   assign diff = cacc_ff - prod_ff;
   assign dmag = diff[PROD_W-1] ? -diff : diff;

   // area from root, saturating
   assign area_v   = (root[ROOT_W-1] || root[ROOT_W-2]) ? AREA_MAX : {root[ROOT_W-3:0], 1'b0};
   assign asum_add = {1'b0, asum_ff} + {1'b0, area_v};

   // divider operands for the current axis
   assign mom_sel = mom_ff[axis_ff];
   assign dvd     = mom_sel[MOM_W-1] ? -mom_sel : mom_sel;
   assign dvs     = DVS_W'({asum_ff, 1'b0}) + DVS_W'(asum_ff);

   // quotient with sign restored, saturated to 32 bits
   always_comb begin
      if (!neg_ff) begin
         cen_v = (|quot[MOM_W-1:CEN_W-1]) ? CEN_POS_MAX : quot[CEN_W-1:0];
      end else if ((|quot[MOM_W-1:CEN_W]) || (quot[CEN_W-1] && (|quot[CEN_W-2:0]))) begin
         cen_v = CEN_NEG_MAX;
      end else begin
         cen_v = -quot[CEN_W-1:0];
      end
   end

   assign rsp_load = (state_ff == BS_EMIT) && (!rsp_valid_ff || rsp_ready);

   // sequencer and datapath next state
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      tri_in     = tri_ff;
      e_in       = e_ff;
      f_in       = f_ff;
      s_in       = s_ff;
      iss_in     = iss_ff;
      ptag_in    = iss_ff;
      pvld_in    = 1'b0;
      prod_in    = opa * opb;
      cacc_in    = cacc_ff;
      n_in       = n_ff;
      sq_in      = sq_ff;
      area_in    = area_ff;
      asum_in    = asum_ff;
      mom_in     = mom_ff;
      axis_in    = axis_ff;
      neg_in     = neg_ff;
      cen_in     = cen_ff;
      zero_in    = zero_ff;
      pop        = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;

      // issue one product a cycle while the schedule runs
      if ((state_ff == BS_CROSS || state_ff == BS_MOMENT) && iss_ff != MS_DONE
          && iss_ff != MS_MXL) begin
         pvld_in = 1'b1;
         iss_in  = mstep_type'(5'(iss_ff + 5'd1));
      end
      if (state_ff == BS_MOMENT && iss_ff != MS_DONE) begin
         pvld_in = 1'b1;
         iss_in  = mstep_type'(5'(iss_ff + 5'd1));
      end

      // retire the registered product
      if (pvld_ff) begin
         case (ptag_ff)
            MS_CX0, MS_CY0, MS_CZ0: cacc_in = prod_ff;
            MS_CX1: n_in[0] = dmag[NRM_W+1:2];
            MS_CY1: n_in[1] = dmag[NRM_W+1:2];
            MS_CZ1: n_in[2] = dmag[NRM_W+1:2];
            MS_SQ0H, MS_SQ1H, MS_SQ2H: sq_in = sq_ff + {prod_ff[NRM_W-1:0], {NRM_W{1'b0}}};
            MS_SQ0M, MS_SQ1M, MS_SQ2M: sq_in = sq_ff + (SQ_W'(prod_ff[NRM_W-1:0]) << 33);
            MS_SQ0L, MS_SQ1L, MS_SQ2L: sq_in = sq_ff + SQ_W'(prod_ff[NRM_W-1:0]);
            MS_MXL: mom_in[0] = mom_ff[0] + MOM_W'(prod_ff);
            MS_MXH: mom_in[0] = mom_ff[0] + (MOM_W'(prod_ff) << 32);
            MS_MYL: mom_in[1] = mom_ff[1] + MOM_W'(prod_ff);
            MS_MYH: mom_in[1] = mom_ff[1] + (MOM_W'(prod_ff) << 32);
            MS_MZL: mom_in[2] = mom_ff[2] + MOM_W'(prod_ff);
            MS_MZH: mom_in[2] = mom_ff[2] + (MOM_W'(prod_ff) << 32);
            default: cacc_in = cacc_ff;
         endcase
      end

      case (state_ff)
         BS_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               job_in = head_job;
               tri_in = 1'b0;
               if (head_job.quad) begin
                  state_in = BS_EDGE;
               end else begin
                  axis_in  = '0;
                  state_in = BS_DSETUP;
               end
            end
         end
         BS_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e_in[k] = EDGE_W'($signed(vb[k])) - EDGE_W'($signed(va[k]));
               f_in[k] = EDGE_W'($signed(vc[k])) - EDGE_W'($signed(va[k]));
               s_in[k] = SUM_W'($signed(va[k])) + SUM_W'($signed(vb[k]))
                         + SUM_W'($signed(vc[k]));
            end
            sq_in    = '0;
            iss_in   = MS_CX0;
            state_in = BS_CROSS;
         end
         BS_CROSS: begin
            // squares are complete once the last one has retired
            if (iss_ff == MS_MXL && !pvld_ff) begin
               sqrt_start = 1'b1;
               state_in   = BS_SQRT;
            end
         end
         BS_SQRT: begin
            if (sqrt_done) begin
               area_in  = area_v;
               asum_in  = asum_add[AREA_W] ? AREA_MAX : asum_add[AREA_W-1:0];
               state_in = BS_MOMENT;
            end
         end
         BS_MOMENT: begin
            if (iss_ff == MS_DONE && !pvld_ff) begin
               if (!tri_ff) begin
                  tri_in   = 1'b1;
                  state_in = BS_EDGE;
               end else if (job_ff.eos) begin
                  axis_in  = '0;
                  state_in = BS_DSETUP;
               end else begin
                  state_in = BS_IDLE;
               end
            end
         end
         BS_DSETUP: begin
            if (asum_ff == '0) begin
               for (int k = 0; k < 3; k++) begin
                  cen_in[k] = '0;
               end
               zero_in  = 1'b1;
               state_in = BS_EMIT;
            end else begin
               zero_in   = 1'b0;
               neg_in    = mom_sel[MOM_W-1];
               div_start = 1'b1;
               state_in  = BS_DIV;
            end
         end
         BS_DIV: begin
            if (div_done) begin
               cen_in[axis_ff] = cen_v;
               if (axis_ff == 2'd2) begin
                  state_in = BS_EMIT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = BS_DSETUP;
               end
            end
         end
         BS_EMIT: begin
            if (rsp_load) begin
               asum_in = '0;
               for (int k = 0; k < 3; k++) begin
                  mom_in[k] = '0;
               end
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_centroid_x = rsp_cx_ff;
   assign rsp_centroid_y = rsp_cy_ff;
   assign rsp_centroid_z = rsp_cz_ff;
   assign rsp_slice_area = rsp_area_ff;
   assign rsp_area_zero  = rsp_zero_ff;

   // control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         iss_ff       <= MS_DONE;
         pvld_ff      <= 1'b0;
         asum_ff      <= '0;
         mom_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pvld_ff      <= pvld_in;
         asum_ff      <= asum_in;
         mom_ff       <= mom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      tri_ff  <= tri_in;
      e_ff    <= e_in;
      f_ff    <= f_in;
      s_ff    <= s_in;
      ptag_ff <= ptag_in;
      prod_ff <= prod_in;
      cacc_ff <= cacc_in;
      n_ff    <= n_in;
      sq_ff   <= sq_in;
      area_ff <= area_in;
      axis_ff <= axis_in;
      neg_ff  <= neg_in;
      cen_ff  <= cen_in;
      zero_ff <= zero_in;
      if (rsp_load) begin
         rsp_cx_ff   <= cen_ff[0];
         rsp_cy_ff   <= cen_ff[1];
         rsp_cz_ff   <= cen_ff[2];
         rsp_area_ff <= asum_ff;
         rsp_zero_ff <= zero_ff;
      end
   end

endmodule

/* rtl/quad_area_weighted_centroid.sv */
// quad_area_weighted_centroid: area-weighted centroid of a slice of quad vertices.
// A vertex beat is taken while the job queue has room, so vertices keep coming in while
// the back end works; it treats each quad as two triangles, each 21 products on one
// shared multiplier plus a 64-step square root. An end of slice adds three 128-step
// divisions before the result, unless the slice area is zero.
// Synchronous reset empties the queue and clears all sums; no clearing pass.
module quad_area_weighted_centroid import qawc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CRD_W-1:0]  req_coord_x,
   input  logic [CRD_W-1:0]  req_coord_y,
   input  logic [CRD_W-1:0]  req_coord_z,
   input  logic              req_end_of_slice,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CEN_W-1:0]  rsp_centroid_x,
   output logic [CEN_W-1:0]  rsp_centroid_y,
   output logic [CEN_W-1:0]  rsp_centroid_z,
   output logic [AREA_W-1:0] rsp_slice_area,
   output logic              rsp_area_zero
);

   logic      push;
   logic      pop;
   job_type   push_job;
   job_type   head_job;
   qstat_type qstat;

   // vertex gathering
   qawc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_end_of_slice (req_end_of_slice),
      .qstat            (qstat),
      .push             (push),
      .push_job         (push_job)
   );

   // job queue
   qawc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // triangle math and slice result
   qawc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_centroid_x (rsp_centroid_x),
      .rsp_centroid_y (rsp_centroid_y),
      .rsp_centroid_z (rsp_centroid_z),
      .rsp_slice_area (rsp_slice_area),
      .rsp_area_zero  (rsp_area_zero)
   );

endmodule
